[rtl/slr_pkg.sv]
// ----------------------------------------------------------------------------
// slr_pkg
// shared constants, register map, and control types for the rate limiter
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int MAX_STAMPS  = 64;
  localparam int TIME_BITS   = 48;
  localparam int NUM_CLASSES = 4;
  localparam int CLASS_W     = 2;
  localparam int WIN_W       = 32;
  localparam int LIM_W       = 7;
  localparam int CNT_W       = 32;
  localparam int DATA_W      = 32;

  localparam int HEAD_W = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
  localparam int FILL_W = $clog2(MAX_STAMPS + 1);
  localparam int ADDR_W = $clog2(NUM_CLASSES * MAX_STAMPS);
  localparam int DEPTH  = NUM_CLASSES * MAX_STAMPS;

  // widths used for the compares
  localparam int AGE_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int LCMP_W = (LIM_W > FILL_W) ? LIM_W : FILL_W;

  // register map
  localparam int NUM_REGS  = 5;
  localparam int PADDR_W   = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SESSION = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_MOVE    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_CHAT    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_ACTION  = REG_IDX_W'(4);

  localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(1000);
  localparam logic [LIM_W-1:0] LIMIT_RST  = LIM_W'(16);

  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [HEAD_W:0]   MAX_POS     = (HEAD_W + 1)'(MAX_STAMPS);
  localparam logic [LCMP_W-1:0] MAX_LIM     = LCMP_W'(MAX_STAMPS);

  typedef struct packed {
    logic [WIN_W-1:0]                  window;
    logic [NUM_CLASSES-1:0][LIM_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic expired;
  } dp_stat_t;

  // ring position modulo MAX_STAMPS, sum is below twice the ring size
  function automatic logic [HEAD_W-1:0] wrap_pos(input logic [HEAD_W:0] sum);
    logic [HEAD_W:0] adj;
    adj = (sum >= MAX_POS) ? (sum - MAX_POS) : sum;
    return adj[HEAD_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLASS_W-1:0] cls,
                                                  input logic [HEAD_W-1:0] pos);
    return ADDR_W'(cls) * ADDR_W'(MAX_STAMPS) + ADDR_W'(pos);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

[rtl/slr_ram.sv]
// ----------------------------------------------------------------------------
// slr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module slr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/slr_regs.sv]
// ----------------------------------------------------------------------------
// slr_regs
// apb configuration registers: window length and per-class limits
// ----------------------------------------------------------------------------
module slr_regs
  import slr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window <= WINDOW_RST;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cfg.limit[i] <= LIMIT_RST;
      end
    end else if (wr_en) begin
      case (idx)
        REG_WINDOW:  cfg.window   <= pwdata[WIN_W-1:0];
        REG_SESSION: cfg.limit[0] <= pwdata[LIM_W-1:0];
        REG_MOVE:    cfg.limit[1] <= pwdata[LIM_W-1:0];
        REG_CHAT:    cfg.limit[2] <= pwdata[LIM_W-1:0];
        REG_ACTION:  cfg.limit[3] <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW:  prdata = DATA_W'(cfg.window);
      REG_SESSION: prdata = DATA_W'(cfg.limit[0]);
      REG_MOVE:    prdata = DATA_W'(cfg.limit[1]);
      REG_CHAT:    prdata = DATA_W'(cfg.limit[2]);
      REG_ACTION:  prdata = DATA_W'(cfg.limit[3]);
      default:     prdata = '0;
    endcase
  end

endmodule

[rtl/slr_ctrl.sv]
// ----------------------------------------------------------------------------
// slr_ctrl
// sequencer: latch request, pop expired stamps one at a time, decide
// ----------------------------------------------------------------------------
module slr_ctrl
  import slr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CMP,
    ST_DECIDE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_LOOK;
      ST_LOOK:   state_next = stat.empty ? ST_DECIDE : ST_CMP;
      ST_CMP:    state_next = stat.expired ? ST_LOOK : ST_DECIDE;
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.load   = (state == ST_IDLE) && start;
  assign cmd.pop    = (state == ST_CMP) && stat.expired;
  assign cmd.decide = (state == ST_DECIDE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_decide_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> !busy)
    else $error("busy held past decision");

endmodule

[rtl/slr_dp.sv]
// ----------------------------------------------------------------------------
// slr_dp
// datapath: per-class ring pointers, stamp store, age compare, counters
// ----------------------------------------------------------------------------
module slr_dp
  import slr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic [CLASS_W-1:0]   req_class,
  input  logic [TIME_BITS-1:0] now_ms,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic                 done,
  output logic                 admitted,
  output logic [CNT_W-1:0]     admit_count,
  output logic [CNT_W-1:0]     drop_count
);

  logic [CLASS_W-1:0]   cls_q;
  logic [TIME_BITS-1:0] now_q;

  logic [NUM_CLASSES-1:0][HEAD_W-1:0] head;
  logic [NUM_CLASSES-1:0][FILL_W-1:0] fill;
  logic [NUM_CLASSES-1:0][CNT_W-1:0]  admit_tot;
  logic [NUM_CLASSES-1:0][CNT_W-1:0]  drop_tot;

  logic [HEAD_W-1:0]    cur_head;
  logic [FILL_W-1:0]    cur_fill;
  logic [TIME_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0] age;
  logic [LCMP_W-1:0]    lim;
  logic [LCMP_W-1:0]    eff_lim;
  logic                 admit;
  logic                 we;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic [CNT_W-1:0]     admit_next;
  logic [CNT_W-1:0]     drop_next;

  assign cur_head = head[cls_q];
  assign cur_fill = fill[cls_q];

  // oldest stamp of the class, data arrives the cycle after
  assign raddr = slot_addr(cls_q, cur_head);
  assign waddr = slot_addr(cls_q, wrap_pos((HEAD_W + 1)'(cur_head) + (HEAD_W + 1)'(cur_fill)));

  assign age          = now_q - rd_data;
  assign stat.expired = AGE_W'(age) >= AGE_W'(cfg.window);
  assign stat.empty   = (cur_fill == '0);

  assign lim     = LCMP_W'(cfg.limit[cls_q]);
  assign eff_lim = (lim > MAX_LIM) ? MAX_LIM : lim;
  assign admit   = LCMP_W'(cur_fill) < eff_lim;
  assign we      = cmd.decide && admit;

  assign admit_next = admit ? sat_inc(admit_tot[cls_q]) : admit_tot[cls_q];
  assign drop_next  = admit ? drop_tot[cls_q] : sat_inc(drop_tot[cls_q]);

  slr_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (DEPTH)
  ) u_stamps (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (now_q),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head[i]      <= '0;
        fill[i]      <= '0;
        admit_tot[i] <= '0;
        drop_tot[i]  <= '0;
      end
    end else begin
      done <= cmd.decide;
      if (cmd.pop) begin
        head[cls_q] <= wrap_pos((HEAD_W + 1)'(cur_head) + (HEAD_W + 1)'(1));
        fill[cls_q] <= cur_fill - FILL_W'(1);
      end
      if (cmd.decide) begin
        if (admit) begin
          fill[cls_q] <= cur_fill + FILL_W'(1);
        end
        admit_tot[cls_q] <= admit_next;
        drop_tot[cls_q]  <= drop_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cls_q <= req_class;
      now_q <= now_ms;
    end
    if (cmd.decide) begin
      admitted    <= admit;
      admit_count <= admit_next;
      drop_count  <= drop_next;
    end
  end

  a_decide_done: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> done)
    else $error("decision without result strobe");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty ring");

  // ring fill stays within the ring size whenever a pop or a decision runs
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop || cmd.decide) |-> (cur_fill <= FILL_W'(MAX_STAMPS)))
    else $error("ring fill above capacity");

endmodule

[rtl/sliding_log_rate_limiter.sv]
// ----------------------------------------------------------------------------
// sliding_log_rate_limiter
// sliding-window-log rate limiter for four request classes
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low; req_class and
// now_ms are sampled at that edge. The block pops expired stamps from the
// front of that class's ring, one at a time (read of the stamp ram, then
// a 48-bit age compare), admits the request if fewer stamps remain than the
// class limit, and reports admitted, admit_count and drop_count for one cycle
// with done high. The receiver cannot stall: sample the result whenever done
// is high. A new request is not taken while one is in flight: busy stays high
// through the look, compare and decide states, and the single read port of
// the stamp ram makes the pop loop sequential. The next request may be
// started in the same cycle that done is high. Configuration is to be written
// over the apb port only while the block is idle, a rule for the user that
// the block itself does not enforce.
module sliding_log_rate_limiter
  import slr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 start,
  output logic                 busy,
  input  logic [CLASS_W-1:0]   req_class,
  input  logic [TIME_BITS-1:0] now_ms,
  // result side, done high for one cycle per item
  output logic                 done,
  output logic                 admitted,
  output logic [CNT_W-1:0]     admit_count,
  output logic [CNT_W-1:0]     drop_count,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // window and limits, read by the datapath while an item runs
  slr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: idle, look up oldest stamp, compare, decide
  slr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // ring state, stamp ram, counters and result registers
  slr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_class   (req_class),
    .now_ms      (now_ms),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .admitted    (admitted),
    .admit_count (admit_count),
    .drop_count  (drop_count)
  );

endmodule

[tb/sv/sliding_log_rate_limiter_tb.sv]
// ----------------------------------------------------------------------------
// sliding_log_rate_limiter_tb
// self-checking bench for the four-class sliding-window-log rate limiter
// ----------------------------------------------------------------------------
// Requests are queued by the sequence block and fed to the block by a
// bursty driver. A local predictor keeps its own stamp rings, fills and
// counters, works out the verdict of every accepted request and queues it.
// The monitor checks each done strobe against the oldest queued verdict.
// The run walks through several register settings: minimum, zero and
// maximum windows, zero limits and limits above the ring size, timestamps
// that wrap, and rings that fill and then expire in one go.
// ----------------------------------------------------------------------------
module sliding_log_rate_limiter_tb;
  import slr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // request classes as the req_class port encodes them
  typedef enum logic [CLASS_W-1:0] {
    CLS_SESSION,
    CLS_MOVE,
    CLS_CHAT,
    CLS_ACTION
  } class_e;

  typedef struct packed {
    logic [CLASS_W-1:0]   cls;
    logic [TIME_BITS-1:0] stamp;
  } request_t;

  typedef struct packed {
    logic             admitted;
    logic [CNT_W-1:0] admits;
    logic [CNT_W-1:0] drops;
  } verdict_t;

  // idle cycles without any accepted item or result before giving up; covers
  // the longest item, one that pops a full ring, plus a sender gap and the final drain
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 4 + 2 * MAX_STAMPS + 8;
  localparam int MAX_REPORTS    = 10;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 start      = 1'b0;
  logic [CLASS_W-1:0]   req_class  = '0;
  logic [TIME_BITS-1:0] now_ms     = '0;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [PADDR_W-1:0]   paddr      = '0;
  logic [DATA_W-1:0]    pwdata     = '0;

  logic                 busy;
  logic                 done;
  logic                 admitted;
  logic [CNT_W-1:0]     admit_count;
  logic [CNT_W-1:0]     drop_count;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  initial forever #4 clk = ~clk;

  sliding_log_rate_limiter dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_class   (req_class),
    .now_ms      (now_ms),
    .done        (done),
    .admitted    (admitted),
    .admit_count (admit_count),
    .drop_count  (drop_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the registers and the rings
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]     cfg_window;
  logic [LIM_W-1:0]     cfg_limit  [NUM_CLASSES];
  logic [TIME_BITS-1:0] stamp_log  [NUM_CLASSES][MAX_STAMPS];
  logic [HEAD_W-1:0]    log_head   [NUM_CLASSES];
  logic [FILL_W-1:0]    log_fill   [NUM_CLASSES];
  logic [CNT_W-1:0]     admit_tally[NUM_CLASSES];
  logic [CNT_W-1:0]     drop_tally [NUM_CLASSES];

  request_t requests_todo[$];   // items waiting for the driver
  verdict_t verdicts_due[$];    // verdicts of accepted items, oldest first

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int err_count    = 0;
  int admits_seen  = 0;
  int drops_seen   = 0;
  int settings_cnt = 0;
  int idle_cycles  = 0;

  logic     item_taken = 1'b0;
  int       burst_left = 1;
  int       gap_left   = 0;
  verdict_t want;

  initial begin
    cfg_window = WINDOW_RST;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cfg_limit[c]   = LIMIT_RST;
      log_head[c]    = '0;
      log_fill[c]    = '0;
      admit_tally[c] = '0;
      drop_tally[c]  = '0;
    end
  end

  function automatic void note_error(input string msg);
    if (err_count < MAX_REPORTS) $display("tb: mismatch: %s", msg);
    err_count++;
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // one request: expire old stamps, then admit if the ring is below the limit
  function automatic verdict_t limit_request(input logic [CLASS_W-1:0] cls,
                                             input logic [TIME_BITS-1:0] stamp);
    logic [TIME_BITS-1:0] age;
    logic [LIM_W-1:0]     cap;
    logic                 keep;
    verdict_t             v;
    // limits above the ring size act as a full ring
    cap = (cfg_limit[cls] > LIM_W'(MAX_STAMPS)) ? LIM_W'(MAX_STAMPS) : cfg_limit[cls];
    keep = 1'b0;
    while (log_fill[cls] != 0 && !keep) begin
      // age wraps with the timestamp; exactly one window old counts as expired
      age = stamp - stamp_log[cls][log_head[cls]];
      if (age < TIME_BITS'(cfg_window)) begin
        keep = 1'b1;
      end else begin
        log_head[cls] = log_head[cls] + 1'b1;
        log_fill[cls] = log_fill[cls] - 1'b1;
      end
    end
    if (LIM_W'(log_fill[cls]) >= cap) begin
      drop_tally[cls] = bump(drop_tally[cls]);
      v.admitted = 1'b0;
    end else begin
      stamp_log[cls][HEAD_W'(log_head[cls] + log_fill[cls])] = stamp;
      log_fill[cls] = log_fill[cls] + 1'b1;
      admit_tally[cls] = bump(admit_tally[cls]);
      v.admitted = 1'b1;
    end
    v.admits = admit_tally[cls];
    v.drops  = drop_tally[cls];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: inputs change on the falling edge, in bursts with random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (item_taken) begin
      requests_todo.delete(0);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        // now and then a long stretch with no gaps at all
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left   = $urandom_range(0, 12);
        end
      end
    end
    if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (!rst && requests_todo.size() > 0) begin
      // start stays high while busy, the item is held until taken
      start     <= 1'b1;
      req_class <= requests_todo[0].cls;
      now_ms    <= requests_todo[0].stamp;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples on the rising edge, checks results, predicts accepts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_taken  <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (verdicts_due.size() == 0) begin
          note_error($sformatf("result with nothing pending: admitted=%0b admits=%0d drops=%0d",
                               admitted, admit_count, drop_count));
        end else begin
          want = verdicts_due[0];
          verdicts_due.delete(0);
          if (admitted !== want.admitted || admit_count !== want.admits ||
              drop_count !== want.drops) begin
            note_error($sformatf("expected admitted=%0b admits=%0d drops=%0d, got %0b %0d %0d",
                                 want.admitted, want.admits, want.drops,
                                 admitted, admit_count, drop_count));
          end
          if (want.admitted) admits_seen++;
          else drops_seen++;
        end
      end
      // the next item may be taken in the same cycle as a result
      if (start && !busy) begin
        verdicts_due.insert(verdicts_due.size(), limit_request(req_class, now_ms));
        accepted_cnt++;
      end
      item_taken  <= start && !busy;
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles with no progress
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic [CLASS_W-1:0] cls,
                               input logic [TIME_BITS-1:0] stamp);
    request_t r;
    r.cls   = cls;
    r.stamp = stamp;
    requests_todo.insert(requests_todo.size(), r);
    queued_cnt++;
  endtask

  // every queued item accepted and every verdict returned
  task automatic await_quiet();
    while (accepted_cnt != queued_cnt || verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write: setup cycle, then access until pready, shadow follows the write
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WINDOW:  cfg_window           = data[WIN_W-1:0];
      REG_SESSION: cfg_limit[CLS_SESSION] = data[LIM_W-1:0];
      REG_MOVE:    cfg_limit[CLS_MOVE]    = data[LIM_W-1:0];
      REG_CHAT:    cfg_limit[CLS_CHAT]    = data[LIM_W-1:0];
      REG_ACTION:  cfg_limit[CLS_ACTION]  = data[LIM_W-1:0];
      default: ;   // unmapped index, ignored
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // limits go out with random upper bits, which the register drops
  task automatic set_config(input logic [WIN_W-1:0] win, input logic [LIM_W-1:0] l_sess,
                            input logic [LIM_W-1:0] l_move, input logic [LIM_W-1:0] l_chat,
                            input logic [LIM_W-1:0] l_act);
    logic [DATA_W-1:0] junk;
    await_quiet();
    junk = $urandom;
    reg_write(REG_WINDOW, DATA_W'(win));
    reg_write(REG_SESSION, {junk[DATA_W-1:LIM_W], l_sess});
    reg_write(REG_MOVE, {junk[DATA_W-1:LIM_W], l_move});
    reg_write(REG_CHAT, {junk[DATA_W-1:LIM_W], l_chat});
    reg_write(REG_ACTION, {junk[DATA_W-1:LIM_W], l_act});
    settings_cnt++;
  endtask

  // random traffic around the current setting: steps sized so that rings
  // hit their limits, some jumps that expire whole rings, a little noise
  task automatic random_traffic(input int n, input logic [TIME_BITS-1:0] base);
    logic [63:0]          eff_sum;
    logic [63:0]          step_max;
    logic [63:0]          rnd;
    logic [TIME_BITS-1:0] t;
    logic [CLASS_W-1:0]   cls;
    int                   pick;
    eff_sum = '0;
    for (int c = 0; c < NUM_CLASSES; c++)
      eff_sum += 64'((cfg_limit[c] > LIM_W'(MAX_STAMPS)) ? LIM_W'(MAX_STAMPS) : cfg_limit[c]);
    eff_sum = (eff_sum < 64'(NUM_CLASSES)) ? 64'(1) : eff_sum / 64'(NUM_CLASSES);
    step_max = 64'(cfg_window) / (64'(2) * eff_sum);
    if (step_max == '0) step_max = 64'(1);
    t   = base;
    cls = CLS_SESSION;
    for (int i = 0; i < n; i++) begin
      // runs of one class fill its ring faster
      if ($urandom_range(0, 1) == 0) cls = CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
      rnd  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_request(cls, rnd[TIME_BITS-1:0]);
      end else begin
        if (pick < 10) t = t + TIME_BITS'(rnd % (64'(2) * 64'(cfg_window) + 64'(2)));
        else t = t + TIME_BITS'(rnd % (step_max + 64'(1)));
        queue_request(cls, t);
      end
    end
  endtask

  function automatic logic [TIME_BITS-1:0] any_stamp();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [WIN_W-1:0]     win;
    logic [LIM_W-1:0]     lims[NUM_CLASSES];
    logic [REG_IDX_W-1:0] spare_idx;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting, extreme timestamps
    queue_request(CLS_SESSION, '0);
    queue_request(CLS_MOVE, '1);
    queue_request(CLS_CHAT, {(TIME_BITS / 2){2'b01}});
    queue_request(CLS_ACTION, {(TIME_BITS / 2){2'b10}});

    // zero limit, small limit, limit above the ring, full-ring limit
    set_config(WIN_W'(10), LIM_W'(0), LIM_W'(2), '1, LIM_W'(MAX_STAMPS));
    queue_request(CLS_SESSION, TIME_BITS'(100));     // zero limit drops
    queue_request(CLS_SESSION, TIME_BITS'(200));
    queue_request(CLS_MOVE, TIME_BITS'(100));
    queue_request(CLS_MOVE, TIME_BITS'(105));
    queue_request(CLS_MOVE, TIME_BITS'(109));        // ring full, drop
    queue_request(CLS_MOVE, TIME_BITS'(110));        // oldest exactly one window old
    queue_request(CLS_MOVE, TIME_BITS'(114));        // still full
    queue_request(CLS_ACTION, '1 - TIME_BITS'(2));  // just before the wrap
    queue_request(CLS_ACTION, TIME_BITS'(5));        // wrapped age 8, kept
    queue_request(CLS_ACTION, TIME_BITS'(7));        // wrapped age 10, expired

    // zero window: every stored stamp expires at once
    set_config('0, LIM_W'(1), LIM_W'(1), LIM_W'(1), LIM_W'(1));
    queue_request(CLS_MOVE, TIME_BITS'(50));
    queue_request(CLS_MOVE, TIME_BITS'(50));
    queue_request(CLS_SESSION, TIME_BITS'(50));

    // fixed settings at the extremes
    set_config(WINDOW_RST, LIMIT_RST, LIMIT_RST, LIMIT_RST, LIMIT_RST);
    random_traffic(150, any_stamp());
    set_config(WIN_W'(1), LIM_W'(1), LIM_W'(2), LIM_W'(3), LIM_W'(4));
    random_traffic(100, any_stamp());
    set_config('1, LIM_W'(MAX_STAMPS), '1, LIM_W'(0), LIM_W'(5));
    random_traffic(100, any_stamp());
    set_config('0, LIM_W'(3), LIM_W'(0), LIM_W'(MAX_STAMPS), LIM_W'(1));
    random_traffic(60, any_stamp());
    // full rings that drain in one request, across the timestamp wrap
    set_config(WIN_W'(5000), LIM_W'(MAX_STAMPS), LIM_W'(MAX_STAMPS), LIM_W'(MAX_STAMPS),
               LIM_W'(100));
    random_traffic(220, '0 - TIME_BITS'(20000));

    // random settings, with a write to an unmapped index in each
    for (int p = 0; p < 5; p++) begin
      win = ($urandom_range(0, 3) == 0) ? WIN_W'($urandom) : WIN_W'($urandom_range(1, 100000));
      for (int c = 0; c < NUM_CLASSES; c++)
        lims[c] = ($urandom_range(0, 4) == 0) ? LIM_W'($urandom_range(0, 127))
                                              : LIM_W'($urandom_range(0, MAX_STAMPS));
      set_config(win, lims[CLS_SESSION], lims[CLS_MOVE], lims[CLS_CHAT], lims[CLS_ACTION]);
      spare_idx = REG_IDX_W'($urandom_range(NUM_REGS, (1 << REG_IDX_W) - 1));
      reg_write(spare_idx, $urandom);
      random_traffic(84, any_stamp());
    end

    await_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (verdicts_due.size() != 0)
      note_error($sformatf("%0d verdicts never returned", verdicts_due.size()));

    $display("tb: %0d requests through %0d register settings, %0d admitted, %0d dropped",
             accepted_cnt, settings_cnt, admits_seen, drops_seen);
    $display("tb: windows 0 to 2^32-1, limits 0 to 127, wrapped stamps, %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
